// File: hdl/keyed_counter_table_defines.svh
// Assertion macros for the keyed counter table.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef KEYED_COUNTER_TABLE_DEFINES_SVH
`define KEYED_COUNTER_TABLE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define KCT_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define KCT_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/kct_pkg.sv
// Shared types and constants for the keyed counter table.
// No dependencies; imported by the top level, kct_ctrl and kct_dp.
`timescale 1ns / 1ps

package kct_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W  = 3;
    localparam int ST_W  = 3;
    localparam int KEY_W = 31;
    localparam int VAL_W = 32;
    localparam int WGT_W = 64;
    localparam int LIM_W = 7;

    localparam logic [LIM_W-1:0] SCAN_MAX = LIM_W'(64);
    localparam logic [WGT_W-1:0] W_MIN    = {1'b1, {(WGT_W-1){1'b0}}};
    localparam logic [WGT_W-1:0] W_MAX    = {1'b0, {(WGT_W-1){1'b1}}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_ADD    = 3'd2,
        OP_SUB    = 3'd3,
        OP_WSUM   = 3'd4,
        OP_SCAN   = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_BAD_AMT   = 3'd4,
        ST_SHORTFALL = 3'd5,
        ST_OVERFLOW  = 3'd6,
        ST_NONE_LOW  = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_UPDATE,
        S_COMMIT,
        S_WRITE,
        S_DRAIN,
        S_FLUSH,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        OUT_STAGE,
        OUT_PEND_MID,
        OUT_PEND_LAST
    } t_out_sel;

    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] addr;
        logic             we_all;
        logic             we_count;
        logic             st_set;
        t_status          st_code;
        logic             calc;
        logic             wsum_done;
        logic             mac_in;
        logic             take;
        logic             out_load;
        t_out_sel         out_sel;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic key_hit;
        logic low_hit;
        logic bad_amt;
        logic lim_zero;
        logic last_slot;
        logic pend_v;
        logic mac_busy;
        logic stage_ok;
        logic out_free;
    } t_sts;

endpackage

// File: hdl/keyed_counter_table.sv
// Keyed counter table, top level: joins the controller and the datapath.
// Depends on kct_pkg, kct_ctrl, kct_dp and keyed_counter_table_defines.svh.
//
// Input channel i_valid/o_stall carries one operation per transfer (opcode,
// key, amount, threshold, weight, scan limit). Output channel o_valid/i_stall
// carries result items; o_last marks the final result of an operation.
// One operation is worked at a time; o_stall stays high until its results
// are handed to the output register.
// Clear and rejects decided from operands go from the decide state straight
// to the result. Insert, add and subtract walk the table one entry per cycle
// to find the key. Weighted sum walks every entry through a five-stage
// multiply-accumulate pipeline, then waits for the pipeline to drain.
// Low scan walks one entry per cycle and emits each match; every match after
// the first needs the output register free before the walk moves on.
// The single-port table memories are read once per cycle.
// With the receiver stalling, the result waits in the output register and
// the next operation is still taken in; a scan pauses its walk instead.
// Reset (synchronous, active low) empties the table at once; no clearing
// pass is needed since entries at or above the live count are never read.
`timescale 1ns / 1ps
`include "keyed_counter_table_defines.svh"

module keyed_counter_table
    import kct_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [KEY_W-1:0]        i_entry_key,
    input  logic signed [VAL_W-1:0] i_amount,
    input  logic signed [VAL_W-1:0] i_low_threshold,
    input  logic signed [WGT_W-1:0] i_weight,
    input  logic [LIM_W-1:0]        i_max_reported,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ST_W-1:0]         o_status,
    output logic signed [VAL_W-1:0] o_new_count,
    output logic [KEY_W-1:0]        o_found_key,
    output logic signed [WGT_W-1:0] o_weighted_total,
    output logic                    o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    kct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    kct_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_opcode         (i_opcode),
        .i_entry_key      (i_entry_key),
        .i_amount         (i_amount),
        .i_low_threshold  (i_low_threshold),
        .i_weight         (i_weight),
        .i_max_reported   (i_max_reported),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_new_count      (o_new_count),
        .o_found_key      (o_found_key),
        .o_weighted_total (o_weighted_total),
        .o_last           (o_last)
    );

    `KCT_ASSERT_IMPLIES(a_out_load_free, w_cmd.out_load, w_sts.out_free, "result loaded over a held transfer")
    `KCT_ASSERT_IMPLIES(a_idle_no_write, !o_stall, !(w_cmd.we_all || w_cmd.we_count), "table written while idle")
    `KCT_ASSERT_IMPLIES(a_take_flushes, w_cmd.take && w_sts.pend_v, w_cmd.out_load, "pending scan key dropped")
    `KCT_ASSERT_IMPLIES(a_mac_only_wsum, w_cmd.mac_in, w_sts.op == OP_WSUM, "accumulate outside weighted sum")

endmodule

// File: hdl/kct_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic                                       i_we,
    input  logic [WIDTH-1:0]                           i_wdata,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/kct_ctrl.sv
// Controller state machine: sequences decide, table walk, update and result.
// Depends on kct_pkg; drives the datapath through t_cmd, reads t_sts.
`timescale 1ns / 1ps

module kct_ctrl
    import kct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_live,  n_live;
    logic [IDX_W-1:0] r_idx,   n_idx;
    logic             w_at_end;
    logic             w_adv;
    logic [IDX_W-1:0] w_nxt_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_idx   <= n_idx;
        end
    end

    assign w_at_end  = (CNT_W'(r_idx) == (r_live - CNT_W'(1)));
    assign w_nxt_idx = r_idx + IDX_W'(1);
    assign o_stall   = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_live        = r_live;
        n_idx         = r_idx;
        w_adv         = 1'b0;
        o_cmd         = '0;
        o_cmd.addr    = r_idx;
        o_cmd.st_code = ST_OK;
        o_cmd.out_sel = OUT_STAGE;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end

            S_DECIDE: begin
                o_cmd.addr = '0;
                n_idx      = '0;
                n_state    = S_RESULT;
                unique case (i_sts.op)
                    OP_CLEAR: begin
                        n_live       = '0;
                        o_cmd.st_set = 1'b1;
                    end
                    OP_INSERT: begin
                        if (r_live == CNT_W'(CAPACITY)) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else if (r_live == '0) begin
                            n_state = S_WRITE;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    OP_ADD, OP_SUB: begin
                        if (i_sts.bad_amt) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_BAD_AMT;
                        end else if (r_live == '0) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_NOT_FOUND;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    OP_WSUM: begin
                        if (r_live == '0) begin
                            o_cmd.st_set = 1'b1;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    OP_SCAN: begin
                        if (r_live == '0 || i_sts.lim_zero) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_NONE_LOW;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        o_cmd.st_set = 1'b1;
                    end
                endcase
            end

            S_WALK: begin
                unique case (i_sts.op)
                    OP_INSERT, OP_ADD, OP_SUB: begin
                        if (i_sts.key_hit) begin
                            if (i_sts.op == OP_INSERT) begin
                                o_cmd.st_set  = 1'b1;
                                o_cmd.st_code = ST_DUPLICATE;
                                n_state       = S_RESULT;
                            end else begin
                                n_state = S_UPDATE;
                            end
                        end else if (w_at_end) begin
                            if (i_sts.op == OP_INSERT) begin
                                n_state = S_WRITE;
                            end else begin
                                o_cmd.st_set  = 1'b1;
                                o_cmd.st_code = ST_NOT_FOUND;
                                n_state       = S_RESULT;
                            end
                        end else begin
                            w_adv = 1'b1;
                        end
                    end
                    OP_WSUM: begin
                        o_cmd.mac_in = 1'b1;
                        if (w_at_end) begin
                            n_state = S_DRAIN;
                        end else begin
                            w_adv = 1'b1;
                        end
                    end
                    OP_SCAN: begin
                        if (i_sts.low_hit) begin
                            if (!i_sts.pend_v || i_sts.out_free) begin
                                o_cmd.take     = 1'b1;
                                o_cmd.out_load = i_sts.pend_v;
                                o_cmd.out_sel  = OUT_PEND_MID;
                                if (i_sts.last_slot || w_at_end) begin
                                    n_state = S_FLUSH;
                                end else begin
                                    w_adv = 1'b1;
                                end
                            end
                        end else if (w_at_end) begin
                            n_state = S_FLUSH;
                        end else begin
                            w_adv = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.st_set = 1'b1;
                        n_state      = S_RESULT;
                    end
                endcase
                if (w_adv) begin
                    o_cmd.addr = w_nxt_idx;
                    n_idx      = w_nxt_idx;
                end
            end

            S_UPDATE: begin
                o_cmd.calc = 1'b1;
                n_state    = S_COMMIT;
            end

            S_COMMIT: begin
                o_cmd.we_count = i_sts.stage_ok;
                n_state        = S_RESULT;
            end

            S_WRITE: begin
                o_cmd.addr   = r_live[IDX_W-1:0];
                o_cmd.we_all = 1'b1;
                o_cmd.st_set = 1'b1;
                n_live       = r_live + CNT_W'(1);
                n_state      = S_RESULT;
            end

            S_DRAIN: begin
                if (!i_sts.mac_busy) begin
                    o_cmd.wsum_done = 1'b1;
                    n_state         = S_RESULT;
                end
            end

            S_FLUSH: begin
                if (i_sts.pend_v) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_PEND_LAST;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.st_set  = 1'b1;
                    o_cmd.st_code = ST_NONE_LOW;
                    n_state       = S_RESULT;
                end
            end

            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/kct_dp.sv
// Datapath: operand registers, table memories, compare, multiply-accumulate
// pipeline, result staging and output register. Depends on kct_pkg, kct_ram.
`timescale 1ns / 1ps

module kct_dp
    import kct_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [KEY_W-1:0]        i_entry_key,
    input  logic signed [VAL_W-1:0] i_amount,
    input  logic signed [VAL_W-1:0] i_low_threshold,
    input  logic signed [WGT_W-1:0] i_weight,
    input  logic [LIM_W-1:0]        i_max_reported,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ST_W-1:0]         o_status,
    output logic signed [VAL_W-1:0] o_new_count,
    output logic [KEY_W-1:0]        o_found_key,
    output logic signed [WGT_W-1:0] o_weighted_total,
    output logic                    o_last
);

    // operands
    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_amt;
    logic [VAL_W-1:0] r_thr;
    logic [WGT_W-1:0] r_weight;
    logic [LIM_W-1:0] r_lim;

    // table read data
    logic [KEY_W-1:0] w_rd_key;
    logic [VAL_W-1:0] w_rd_count;
    logic [VAL_W-1:0] w_rd_thr;
    logic [WGT_W-1:0] w_rd_weight;
    logic [VAL_W-1:0] w_count_wdata;

    // staging
    t_status          r_st_status;
    logic [VAL_W-1:0] r_st_count;
    logic [WGT_W-1:0] r_st_total;

    // scan
    logic             r_pend_v;
    logic [KEY_W-1:0] r_pend_key;
    logic [LIM_W-1:0] r_nfound;

    // multiply-accumulate pipeline
    logic             r_va, r_vb, r_vc, r_vd;
    logic             r_a_negc, r_a_negw;
    logic [VAL_W-1:0] r_a_mc;
    logic [WGT_W-1:0] r_a_mw;
    logic             r_b_neg;
    logic [WGT_W-1:0] r_b_plo, r_b_phi;
    logic             r_c_neg, r_c_sat;
    logic [WGT_W-1:0] r_c_mag;
    logic             r_d_sat;
    logic [WGT_W-1:0] r_d_prod;
    logic [WGT_W-1:0] r_acc;
    logic             r_sat;
    logic [WGT_W:0]   w_mag;
    logic             w_mag_sat;
    logic [WGT_W-1:0] w_sum;
    logic             w_sum_ovf;

    // add / subtract
    logic signed [VAL_W:0] w_add;
    logic [VAL_W-1:0]      w_diff;

    // output register
    logic             r_o_valid;
    t_status          r_o_status;
    logic [VAL_W-1:0] r_o_count;
    logic [KEY_W-1:0] r_o_key;
    logic [WGT_W-1:0] r_o_total;
    logic             r_o_last;
    logic             w_out_free;

    assign w_count_wdata = i_cmd.we_all ? r_amt : r_st_count;

    kct_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_addr  (i_cmd.addr),
        .i_we    (i_cmd.we_all),
        .i_wdata (r_key),
        .o_rdata (w_rd_key)
    );

    kct_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_count_ram (
        .i_clk   (i_clk),
        .i_addr  (i_cmd.addr),
        .i_we    (i_cmd.we_all | i_cmd.we_count),
        .i_wdata (w_count_wdata),
        .o_rdata (w_rd_count)
    );

    kct_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_thr_ram (
        .i_clk   (i_clk),
        .i_addr  (i_cmd.addr),
        .i_we    (i_cmd.we_all),
        .i_wdata (r_thr),
        .o_rdata (w_rd_thr)
    );

    kct_ram #(.WIDTH(WGT_W), .DEPTH(CAPACITY)) u_weight_ram (
        .i_clk   (i_clk),
        .i_addr  (i_cmd.addr),
        .i_we    (i_cmd.we_all),
        .i_wdata (r_weight),
        .o_rdata (w_rd_weight)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_opcode);
            r_key    <= i_entry_key;
            r_amt    <= i_amount;
            r_thr    <= i_low_threshold;
            r_weight <= i_weight;
            r_lim    <= (i_max_reported > SCAN_MAX) ? SCAN_MAX : i_max_reported;
        end
    end

    assign w_add  = $signed({w_rd_count[VAL_W-1], w_rd_count})
                  + $signed({r_amt[VAL_W-1], r_amt});
    assign w_diff = w_rd_count - r_amt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_set) begin
            r_st_status <= i_cmd.st_code;
            r_st_count  <= '0;
            r_st_total  <= '0;
        end else if (i_cmd.calc) begin
            r_st_total <= '0;
            if (r_op == OP_ADD) begin
                if (w_add > $signed({1'b0, {(VAL_W-1){1'b1}}})) begin
                    r_st_status <= ST_OVERFLOW;
                    r_st_count  <= w_rd_count;
                end else begin
                    r_st_status <= ST_OK;
                    r_st_count  <= w_add[VAL_W-1:0];
                end
            end else begin
                if ($signed(w_rd_count) < $signed(r_amt)) begin
                    r_st_status <= ST_SHORTFALL;
                    r_st_count  <= w_rd_count;
                end else begin
                    r_st_status <= ST_OK;
                    r_st_count  <= w_diff;
                end
            end
        end else if (i_cmd.wsum_done) begin
            r_st_status <= r_sat ? ST_OVERFLOW : ST_OK;
            r_st_count  <= '0;
            r_st_total  <= r_acc;
        end
    end

    // low scan: one match is held back until the next one (or the end) shows
    // whether it is the final transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_nfound <= '0;
        end else if (i_cmd.load) begin
            r_pend_v <= 1'b0;
            r_nfound <= '0;
        end else if (i_cmd.take) begin
            r_pend_v <= 1'b1;
            r_nfound <= r_nfound + LIM_W'(1);
        end else if (i_cmd.out_load && i_cmd.out_sel == OUT_PEND_LAST) begin
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend_key <= w_rd_key;
        end
    end

    // weighted sum: magnitude, two 32x32 partial products, combine, sign, add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_cmd.mac_in;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    assign w_mag     = {1'b0, r_b_phi[VAL_W-1:0], {VAL_W{1'b0}}} + {1'b0, r_b_plo};
    assign w_mag_sat = (|r_b_phi[WGT_W-1:VAL_W]) | w_mag[WGT_W]
                     | (w_mag[WGT_W-1] & ((|w_mag[WGT_W-2:0]) | ~r_b_neg));
    assign w_sum     = r_acc + r_d_prod;
    assign w_sum_ovf = (r_acc[WGT_W-1] == r_d_prod[WGT_W-1])
                     & (w_sum[WGT_W-1] != r_acc[WGT_W-1]);

    always_ff @(posedge i_clk) begin
        r_a_negc <= w_rd_count[VAL_W-1];
        r_a_negw <= w_rd_weight[WGT_W-1];
        r_a_mc   <= w_rd_count[VAL_W-1] ? (VAL_W'(0) - w_rd_count) : w_rd_count;
        r_a_mw   <= w_rd_weight[WGT_W-1] ? (WGT_W'(0) - w_rd_weight) : w_rd_weight;

        r_b_neg  <= r_a_negc ^ r_a_negw;
        r_b_plo  <= r_a_mw[VAL_W-1:0] * r_a_mc;
        r_b_phi  <= r_a_mw[WGT_W-1:VAL_W] * r_a_mc;

        r_c_neg  <= r_b_neg;
        r_c_sat  <= w_mag_sat;
        r_c_mag  <= w_mag[WGT_W-1:0];

        r_d_sat  <= r_c_sat;
        if (r_c_sat) begin
            r_d_prod <= r_c_neg ? W_MIN : W_MAX;
        end else begin
            r_d_prod <= r_c_neg ? (WGT_W'(0) - r_c_mag) : r_c_mag;
        end

        if (i_cmd.load) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (r_vd) begin
            if (w_sum_ovf) begin
                r_acc <= r_acc[WGT_W-1] ? W_MIN : W_MAX;
            end else begin
                r_acc <= w_sum;
            end
            r_sat <= r_sat | r_d_sat | w_sum_ovf;
        end
    end

    // output register
    assign w_out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_sel)
                OUT_STAGE: begin
                    r_o_status <= r_st_status;
                    r_o_count  <= r_st_count;
                    r_o_key    <= '0;
                    r_o_total  <= r_st_total;
                    r_o_last   <= 1'b1;
                end
                OUT_PEND_MID: begin
                    r_o_status <= ST_OK;
                    r_o_count  <= '0;
                    r_o_key    <= r_pend_key;
                    r_o_total  <= '0;
                    r_o_last   <= 1'b0;
                end
                OUT_PEND_LAST: begin
                    r_o_status <= ST_OK;
                    r_o_count  <= '0;
                    r_o_key    <= r_pend_key;
                    r_o_total  <= '0;
                    r_o_last   <= 1'b1;
                end
                default: begin
                    r_o_status <= r_st_status;
                    r_o_count  <= r_st_count;
                    r_o_key    <= '0;
                    r_o_total  <= r_st_total;
                    r_o_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_new_count      = r_o_count;
    assign o_found_key      = r_o_key;
    assign o_weighted_total = r_o_total;
    assign o_last           = r_o_last;

    always_comb begin
        o_sts           = '0;
        o_sts.op        = r_op;
        o_sts.key_hit   = (w_rd_key == r_key);
        o_sts.low_hit   = ($signed(w_rd_count) <= $signed(w_rd_thr));
        o_sts.bad_amt   = (r_op == OP_SUB) ? (r_amt[VAL_W-1] || r_amt == '0)
                                           : r_amt[VAL_W-1];
        o_sts.lim_zero  = (r_lim == '0);
        o_sts.last_slot = (LIM_W'(r_nfound + LIM_W'(1)) == r_lim);
        o_sts.pend_v    = r_pend_v;
        o_sts.mac_busy  = r_va | r_vb | r_vc | r_vd;
        o_sts.stage_ok  = (r_st_status == ST_OK);
        o_sts.out_free  = w_out_free;
    end

endmodule
